[rtl/core/bcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and constants of the cubic Bezier chain segmenter.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int COORD_BITS = 32;

    // weighted sum w1*a + w2*b, weights 0..3
    localparam int SUM_W     = COORD_BITS + 2;
    localparam int MAG_W     = COORD_BITS + 1;

    // divide by 3: q = (m * ceil(2^DIV_SHIFT / 3)) >> DIV_SHIFT, exact for m < 2^MAG_W
    localparam int DIV_SHIFT = COORD_BITS + 2;
    localparam int RECIP_W   = COORD_BITS + 1;
    localparam int K_LO_W    = RECIP_W / 2;
    localparam int K_HI_W    = RECIP_W - K_LO_W;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3;
    localparam logic [K_LO_W-1:0] RECIP_LO = RECIP_FULL[K_LO_W-1:0];
    localparam logic [K_HI_W-1:0] RECIP_HI = RECIP_FULL[RECIP_W-1:K_LO_W];

    localparam int QDEPTH = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    typedef struct packed {
        coord_t [2:0] c;    // c[0] = x, c[1] = y, c[2] = z
    } point_t;

    typedef enum logic [1:0] {
        JOB_PASS,   // four stored points leave unchanged
        JOB_QUAD,   // three-point tail, raised from quadratic
        JOB_LIN     // two-point tail, raised from linear
    } job_kind_t;

    typedef struct packed {
        job_kind_t    kind;
        point_t [3:0] pt;
    } job_t;

endpackage

[rtl/core/bcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_front
// Buffers incoming control points and turns each closed segment into a job.
// ----------------------------------------------------------------------------
module bcs_front
    import bcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  coord_t pos_x,
    input  coord_t pos_y,
    input  coord_t pos_z,
    input  logic   final_point,
    input  logic   q_full,
    output logic   push,
    output job_t   push_job
);

    point_t      store_reg [3];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [1:0]  wr_idx;
    point_t      pt_in;
    logic        accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        pt_in.c[0] = pos_x;
        pt_in.c[1] = pos_y;
        pt_in.c[2] = pos_z;

        push_job.kind  = JOB_PASS;
        push_job.pt[0] = store_reg[0];
        push_job.pt[1] = store_reg[1];
        push_job.pt[2] = store_reg[2];
        push_job.pt[3] = pt_in;
        push = 1'b0;

        unique case (count_reg)
            2'd3:
            begin
                push = accept;
            end
            2'd2:
            begin
                push_job.kind  = JOB_QUAD;
                push_job.pt[2] = pt_in;
                push = accept && final_point;
            end
            2'd1:
            begin
                push_job.kind  = JOB_LIN;
                push_job.pt[1] = pt_in;
                push = accept && final_point;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase

        // fourth point starts the next segment
        wr_idx = (count_reg == 2'd3) ? 2'd0 : count_reg;
        if (final_point)
            count_next = 2'd0;
        else if (count_reg == 2'd3)
            count_next = 2'd1;
        else
            count_next = count_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (accept)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            store_reg[wr_idx] <= pt_in;
    end

endmodule

[rtl/core/bcs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_queue
// Short job queue between the point buffer and the vertex pipeline.
// ----------------------------------------------------------------------------
module bcs_queue
    import bcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    job_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/core/bcs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_back
// Issues four vertices per job and computes each as (w1*a + w2*b) / 3.
// ----------------------------------------------------------------------------
module bcs_back
    import bcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   head_valid,
    input  job_t   head_job,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_stall,
    output coord_t vert_x,
    output coord_t vert_y,
    output coord_t vert_z,
    output logic   segment_end
);

    logic [1:0]  slot_reg;
    logic        adv;
    logic        issue;
    point_t      sel_a;
    point_t      sel_b;
    logic [1:0]  w1;
    logic [1:0]  w2;

    // stage 1: weighted sum
    logic        s1_valid_reg;
    logic        s1_end_reg;
    sum_t        s1_sum_reg [3];
    // stage 2: magnitude and sign
    logic        s2_valid_reg;
    logic        s2_end_reg;
    logic [MAG_W-1:0] s2_mag_reg [3];
    logic [2:0]  s2_neg_reg;
    // stage 3: partial products of the reciprocal multiply
    logic        s3_valid_reg;
    logic        s3_end_reg;
    logic [MAG_W+K_LO_W-1:0] s3_plo_reg [3];
    logic [MAG_W+K_HI_W-1:0] s3_phi_reg [3];
    logic [2:0]  s3_neg_reg;
    // output register
    logic        out_valid_reg;
    logic        out_end_reg;
    coord_t      out_reg [3];

    logic [PROD_W-1:0]     prod [3];
    logic [COORD_BITS-1:0] quo  [3];

    assign adv   = !out_valid_reg || !out_stall;
    assign issue = adv && head_valid;
    assign pop   = issue && (slot_reg == 2'd3);

    function automatic sum_t weigh(input coord_t v, input logic [1:0] w);
        sum_t ext;
        sum_t t;
        ext = {{(SUM_W - COORD_BITS){v[COORD_BITS-1]}}, v};
        t = '0;
        if (w[0])
            t = ext;
        if (w[1])
            t = t + (ext <<< 1);
        weigh = t;
    endfunction

    // vertex selection: endpoints pass through as 3*p / 3
    always_comb
    begin
        sel_a = head_job.pt[slot_reg];
        sel_b = head_job.pt[0];
        w1    = 2'd3;
        w2    = 2'd0;
        unique case (head_job.kind)
            JOB_PASS:
            begin
                sel_a = head_job.pt[slot_reg];
            end
            JOB_QUAD:
            begin
                case (slot_reg)
                    2'd0:
                    begin
                        sel_a = head_job.pt[0];
                    end
                    2'd1:
                    begin
                        sel_a = head_job.pt[0];
                        sel_b = head_job.pt[1];
                        w1 = 2'd1;
                        w2 = 2'd2;
                    end
                    2'd2:
                    begin
                        sel_a = head_job.pt[1];
                        sel_b = head_job.pt[2];
                        w1 = 2'd2;
                        w2 = 2'd1;
                    end
                    default:
                    begin
                        sel_a = head_job.pt[2];
                    end
                endcase
            end
            JOB_LIN:
            begin
                case (slot_reg)
                    2'd0:
                    begin
                        sel_a = head_job.pt[0];
                    end
                    2'd1:
                    begin
                        sel_a = head_job.pt[0];
                        sel_b = head_job.pt[1];
                        w1 = 2'd2;
                        w2 = 2'd1;
                    end
                    2'd2:
                    begin
                        sel_a = head_job.pt[0];
                        sel_b = head_job.pt[1];
                        w1 = 2'd1;
                        w2 = 2'd2;
                    end
                    default:
                    begin
                        sel_a = head_job.pt[1];
                    end
                endcase
            end
            default:
            begin
                sel_a = head_job.pt[slot_reg];
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = {s3_phi_reg[i], {K_LO_W{1'b0}}} + PROD_W'(s3_plo_reg[i]);
            quo[i]  = prod[i][DIV_SHIFT +: COORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 2'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (head_valid)
                slot_reg <= slot_reg + 2'd1;
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_end_reg  <= (slot_reg == 2'd3);
            s2_end_reg  <= s1_end_reg;
            s3_end_reg  <= s2_end_reg;
            out_end_reg <= s3_end_reg;
            s3_neg_reg  <= s2_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_sum_reg[i] <= weigh(sel_a.c[i], w1) + weigh(sel_b.c[i], w2);
                s2_neg_reg[i] <= s1_sum_reg[i][SUM_W-1];
                s2_mag_reg[i] <= s1_sum_reg[i][SUM_W-1]
                                 ? MAG_W'(-s1_sum_reg[i]) : MAG_W'(s1_sum_reg[i]);
                s3_plo_reg[i] <= s2_mag_reg[i] * RECIP_LO;
                s3_phi_reg[i] <= s2_mag_reg[i] * RECIP_HI;
                // truncation toward zero: divide the magnitude, restore the sign
                out_reg[i]    <= s3_neg_reg[i] ? -coord_t'(quo[i]) : coord_t'(quo[i]);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign segment_end = out_end_reg;
    assign vert_x      = out_reg[0];
    assign vert_y      = out_reg[1];
    assign vert_z      = out_reg[2];

endmodule

[rtl/core/bezier_chain_cubic_segmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_chain_cubic_segmenter
// Cuts a point stream into cubic Bezier segments, raising short tails to cubic.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | pos_x, pos_y, pos_z, final_point
//  out      | out_valid / out_stall| vert_x, vert_y, vert_z, segment_end
//
//  A point is taken on any beat with in_stall low; a closed segment becomes
//  a job in a two-entry queue. The vertex pipeline sends one vertex per cycle
//  while a job waits and out_stall is low, four per job, through its sum,
//  magnitude, product and output registers; three points of a long chain give
//  four vertices. in_stall rises only when the job queue is full; out_stall
//  freezes the vertex pipeline. Reset clears counters and queue.
// ----------------------------------------------------------------------------
module bezier_chain_cubic_segmenter
    import bcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  coord_t pos_x,
    input  coord_t pos_y,
    input  coord_t pos_z,
    input  logic   final_point,
    output logic   out_valid,
    input  logic   out_stall,
    output coord_t vert_x,
    output coord_t vert_y,
    output coord_t vert_z,
    output logic   segment_end
);

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    bcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .final_point (final_point),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    bcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .segment_end (segment_end)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cubic Bezier chain segmenter. Point chains go in
// through the valid/stall channel: first a short directed table, then random
// chains. Each vertex out is checked against a chain model in the bench or
// a typed row's own vertices. Input gaps and output stall modes are random.
// ----------------------------------------------------------------------------
module testbench
    import bcs_pkg::*;
();

    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam coord_t C_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_POINTS = 125;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   seg_end;
    } vertex_t;

    // directed stimulus row; typed rows carry their vertices written out
    typedef struct packed {
        point_t        p;
        logic          fin;
        logic          typed;
        logic [2:0]    nres;
        vertex_t [3:0] v;
    } row_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   final_point;
    logic   out_valid;
    logic   out_stall;
    coord_t vert_x;
    coord_t vert_y;
    coord_t vert_z;
    logic   segment_end;

    bezier_chain_cubic_segmenter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .final_point (final_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .segment_end (segment_end)
    );

    // chain model state
    point_t  chain_pts [3];
    int      chain_len;
    vertex_t seg_verts [4];

    vertex_t pending_verts [$];
    row_t    dir_rows [$];
    int      err_count;
    int      burst_left;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void add_row(row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void expect_vertex(vertex_t v);
        pending_verts.insert(pending_verts.size(), v);
    endfunction

    function automatic vertex_t vtx(coord_t x, coord_t y, coord_t z, logic e);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.seg_end = e;
        return v;
    endfunction

    function automatic vertex_t pt_vtx(point_t p, logic e);
        return vtx(p.c[0], p.c[1], p.c[2], e);
    endfunction

    // (wa*a + wb*b) / 3 per axis, truncated toward zero
    function automatic point_t blend_third(point_t a, point_t b, int wa, int wb);
        point_t r;
        longint s;
        for (int i = 0; i < 3; i++)
        begin
            s = longint'(wa) * longint'(a.c[i]) + longint'(wb) * longint'(b.c[i]);
            r.c[i] = coord_t'(s / 3);
        end
        return r;
    endfunction

    // takes one point, fills seg_verts, returns the number of vertices due
    function automatic int advance_chain(point_t p, logic fin);
        int n;
        n = 0;
        if (chain_len == 3)
        begin
            for (int k = 0; k < 3; k++)
                seg_verts[k] = pt_vtx(chain_pts[k], 1'b0);
            seg_verts[3] = pt_vtx(p, 1'b1);
            chain_pts[0] = p;
            chain_len = fin ? 0 : 1;
            return 4;
        end
        chain_pts[chain_len] = p;
        chain_len++;
        if (!fin)
            return 0;
        if (chain_len == 3)
        begin
            seg_verts[0] = pt_vtx(chain_pts[0], 1'b0);
            seg_verts[1] = pt_vtx(blend_third(chain_pts[0], chain_pts[1], 1, 2), 1'b0);
            seg_verts[2] = pt_vtx(blend_third(chain_pts[1], chain_pts[2], 2, 1), 1'b0);
            seg_verts[3] = pt_vtx(chain_pts[2], 1'b1);
            n = 4;
        end
        else if (chain_len == 2)
        begin
            seg_verts[0] = pt_vtx(chain_pts[0], 1'b0);
            seg_verts[1] = pt_vtx(blend_third(chain_pts[0], chain_pts[1], 2, 1), 1'b0);
            seg_verts[2] = pt_vtx(blend_third(chain_pts[0], chain_pts[1], 1, 2), 1'b0);
            seg_verts[3] = pt_vtx(chain_pts[1], 1'b1);
            n = 4;
        end
        chain_len = 0;
        return n;
    endfunction

    function automatic row_t mk_row(coord_t x, coord_t y, coord_t z, logic fin);
        row_t r;
        r = '0;
        r.p.c[0] = x;
        r.p.c[1] = y;
        r.p.c[2] = z;
        r.fin = fin;
        return r;
    endfunction

    function automatic row_t typed_row(row_t r, int n, vertex_t v0, vertex_t v1,
                                       vertex_t v2, vertex_t v3);
        row_t t;
        t = r;
        t.typed = 1'b1;
        t.nres = 3'(n);
        t.v[0] = v0;
        t.v[1] = v1;
        t.v[2] = v2;
        t.v[3] = v3;
        return t;
    endfunction

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 9))
            0: return C_MIN;
            1: return C_MAX;
            2: return coord_t'($urandom_range(0, 20)) - 10;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        $display("%0t ns  mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // drives one point at the falling edge and returns after its beat
    task automatic send_point(row_t r);
        int gap;
        int n;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        pos_x       <= r.p.c[0];
        pos_y       <= r.p.c[1];
        pos_z       <= r.p.c[2];
        final_point <= r.fin;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        burst_left--;
        n = advance_chain(r.p, r.fin);
        if (r.typed)
            n = r.nres;
        for (int k = 0; k < n; k++)
            expect_vertex(r.typed ? r.v[k] : seg_verts[k]);
        @(negedge clk);
    endtask

    // receiver stall pattern: one of four modes, redrawn at random
    initial
    begin
        int mode;
        int cnt;
        out_stall = 1'b0;
        cnt = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 80))
            begin
                @(negedge clk);
                cnt++;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= (cnt[1:0] == 2'd0);
                    default: out_stall <= cnt[3];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verts.size() == 0)
                report_mismatch("unexpected vertex x", vert_x, 0);
            else
            begin
                want = pending_verts.pop_front();
                if (vert_x !== want.x)
                    report_mismatch("vert_x", vert_x, want.x);
                if (vert_y !== want.y)
                    report_mismatch("vert_y", vert_y, want.y);
                if (vert_z !== want.z)
                    report_mismatch("vert_z", vert_z, want.z);
                if (segment_end !== want.seg_end)
                    report_mismatch("segment_end", segment_end, want.seg_end);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int sent;
        int len;
        err_count   = 0;
        burst_left  = 0;
        chain_len   = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        final_point = 1'b0;

        // four-point chain closed on its fourth point: passes unchanged
        add_row(mk_row(C_MIN, C_MAX, 0, 1'b0));
        add_row(mk_row(C_MAX, C_MIN, -1, 1'b0));
        add_row(mk_row(1, -1, C_MIN, 1'b0));
        add_row(typed_row(mk_row(C_MAX, C_MAX, C_MAX, 1'b1), 4,
            vtx(C_MIN, C_MAX, 0, 1'b0), vtx(C_MAX, C_MIN, -1, 1'b0),
            vtx(1, -1, C_MIN, 1'b0), vtx(C_MAX, C_MAX, C_MAX, 1'b1)));
        // lone final point: nothing out
        add_row(typed_row(mk_row(5, 6, 7, 1'b1), 0,
            '0, '0, '0, '0));
        // linear tail at the extremes
        add_row(mk_row(C_MIN, 0, -2, 1'b0));
        add_row(typed_row(mk_row(C_MAX, 3, 0, 1'b1), 4,
            vtx(C_MIN, 0, -2, 1'b0), vtx(-715827883, 1, -1, 1'b0),
            vtx(715827882, 2, 0, 1'b0), vtx(C_MAX, 3, 0, 1'b1)));
        // quadratic tail
        add_row(mk_row(-3, C_MAX, 1, 1'b0));
        add_row(mk_row(0, C_MAX, 1, 1'b0));
        add_row(typed_row(mk_row(3, C_MAX, -1, 1'b1), 4,
            vtx(-3, C_MAX, 1, 1'b0), vtx(-1, C_MAX, 1, 1'b0),
            vtx(1, C_MAX, 0, 1'b0), vtx(3, C_MAX, -1, 1'b1)));
        // six points: a full segment, then a quadratic tail on the shared end
        add_row(mk_row(-7, 11, C_MIN, 1'b0));
        add_row(mk_row(13, -5, -1, 1'b0));
        add_row(mk_row(-1, -2, 2, 1'b0));
        add_row(mk_row(4, 8, -8, 1'b0));
        add_row(mk_row(-5, C_MIN, 1, 1'b0));
        add_row(mk_row(C_MAX, -4, -3, 1'b1));
        // five points: a full segment, then a linear tail
        add_row(mk_row(2, -2, 17, 1'b0));
        add_row(mk_row(-9, 100, -31, 1'b0));
        add_row(mk_row(C_MIN, -1, 5, 1'b0));
        add_row(mk_row(-1, 1, -5, 1'b0));
        add_row(mk_row(-2, C_MAX, C_MIN, 1'b1));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_point(dir_rows[i]);

        // random chains, mostly long enough to pass full segments
        sent = 0;
        while (sent < RANDOM_POINTS)
        begin
            len = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : $urandom_range(4, 13);
            for (int i = 0; i < len; i++)
                send_point(mk_row(rnd_coord(), rnd_coord(), rnd_coord(), i == len - 1));
            sent += len;
        end
        in_valid <= 1'b0;

        while (pending_verts.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/bcs_pkg.sv
rtl/core/bcs_front.sv
rtl/core/bcs_queue.sv
rtl/core/bcs_back.sv
rtl/core/bezier_chain_cubic_segmenter.sv
tb/testbench.sv
